// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 25;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h07;

    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ENABLE = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT,
        ST_SCR_PRIME,
        ST_SCROLL,
        ST_CLEAR,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/text_console_writer_unit.sv =====
// Top level of the text console writer: cursor control, scroll and clear sequencer.
// A put or a newline without scroll uses ST_PUT then ST_DONE; an unused command goes to ST_DONE.
// A read uses ST_RD_ISSUE and ST_RD_WAIT; a clear blanks SCREEN_COLUMNS * SCREEN_ROWS cells.
// A scrolling put adds ST_SCR_PRIME and ST_SCROLL, one cell at a time on the single write port.
// One item is worked on at a time; the next is accepted in the cycle after the result is loaded.
// Reset clears the cursor to the top left, the color to 7 and the cursor enable to 0;
// the cell store is not cleared and holds unknown data until a clear item.
module text_console_writer_unit #(
    parameter int SCREEN_COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
    parameter int SCREEN_ROWS    = tcw_pkg::DEFAULT_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // char_code [7:0], cell_index [18:8], zero fill [23:19]
    input  logic [tcw_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // command [1:0]
    input  logic [tcw_pkg::S_TUSER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // cursor_position [10:0], cell_data [26:11], zero fill [31:27]
    output logic [tcw_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // cursor_shown [0]
    output logic [tcw_pkg::M_TUSER_W-1:0]    o_m_tuser
);

    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL_W      = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;

    localparam logic [AW:0]      COLS_X    = (AW+1)'(SCREEN_COLUMNS);
    localparam logic [AW:0]      CELLS_X   = (AW+1)'(CELL_COUNT);
    localparam logic [AW:0]      MOVE_END  = (AW+1)'(CELL_COUNT - SCREEN_COLUMNS);
    localparam logic [AW-1:0]    PTR_LAST  = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0]    LAST_BASE = AW'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [AW-1:0]    COLS_A    = AW'(SCREEN_COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W:0]   COLS_C    = (COL_W+1)'(SCREEN_COLUMNS);

    t_state r_state, n_state;

    logic [COLOR_W-1:0] r_text_color;
    logic               r_cursor_en;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [AW-1:0]      r_lin, n_lin;
    logic [AW-1:0]      r_ptr, n_ptr;
    logic [CMD_W-1:0]   r_cmd;
    logic [CHAR_W-1:0]  r_char;
    logic [INDEX_W-1:0] r_idx;
    logic [CELL_W-1:0]  r_data, n_data;

    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_shown;
    logic [CELL_W-1:0]  r_out_data;

    logic               w_accept;
    logic               w_out_free;
    logic               w_newline;
    logic               w_wrap;
    logic               w_scroll;
    logic               w_idx_ok;
    logic [CELL_W-1:0]  w_blank;
    logic [AW:0]        w_rd_next;
    logic [AW+INDEX_W-1:0] w_idx_ext;
    logic [AW+POS_W-1:0]   w_lin_ext;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [CELL_W-1:0]  w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [CELL_W-1:0]  w_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_newline  = (r_char == NEWLINE_CODE);
    assign w_wrap     = w_newline || (({1'b0, r_col} + (COL_W+1)'(1)) == COLS_C);
    assign w_scroll   = w_wrap && (r_row == LAST_ROW);
    assign w_blank    = {r_text_color, SPACE_CODE};
    assign w_rd_next  = {1'b0, r_ptr} + COLS_X + (AW+1)'(1);
    assign w_idx_ext  = {{AW{1'b0}}, r_idx};
    assign w_idx_ok   = (32'(r_idx) < 32'(CELL_COUNT));
    assign w_lin_ext  = {{POS_W{1'b0}}, r_lin};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser == CMD_PUT) begin
                        n_state = ST_PUT;
                    end else if (i_s_tuser == CMD_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (i_s_tuser == CMD_READ) begin
                        n_state = ST_RD_ISSUE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_PUT:       n_state = w_scroll ? ST_SCR_PRIME : ST_DONE;
            ST_SCR_PRIME: n_state = ST_SCROLL;
            ST_SCROLL:    n_state = (r_ptr == PTR_LAST) ? ST_DONE : ST_SCROLL;
            ST_CLEAR:     n_state = (r_ptr == PTR_LAST) ? ST_DONE : ST_CLEAR;
            ST_RD_ISSUE:  n_state = ST_RD_WAIT;
            ST_RD_WAIT:   n_state = ST_DONE;
            ST_DONE:      n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        w_we       = 1'b0;
        w_waddr    = r_ptr;
        w_wdata    = w_blank;
        w_re       = 1'b0;
        w_raddr    = w_rd_next[AW-1:0];
        unique case (r_state)
            ST_PUT: begin
                w_we    = !w_newline;
                w_waddr = r_lin;
                w_wdata = {r_text_color, r_char};
            end
            ST_SCR_PRIME: begin
                w_re    = 1'b1;
                w_raddr = COLS_A;
            end
            ST_SCROLL: begin
                w_we    = 1'b1;
                w_wdata = ({1'b0, r_ptr} < MOVE_END) ? w_rdata : w_blank;
                w_re    = (w_rd_next < CELLS_X);
            end
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_RD_ISSUE: begin
                w_re    = w_idx_ok;
                w_raddr = w_idx_ext[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_lin  = r_lin;
        n_ptr  = r_ptr;
        n_data = r_data;
        unique case (r_state)
            ST_IDLE: begin
                n_ptr  = '0;
                n_data = '0;
            end
            ST_PUT: begin
                n_ptr = '0;
                if (!w_wrap) begin
                    n_col = r_col + COL_W'(1);
                    n_lin = r_lin + AW'(1);
                end else if (w_scroll) begin
                    n_col = '0;
                    n_lin = LAST_BASE;
                end else begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                    n_lin = r_lin - AW'(r_col) + COLS_A;
                end
            end
            ST_SCROLL, ST_CLEAR: begin
                n_ptr = r_ptr + AW'(1);
            end
            ST_RD_WAIT: begin
                n_data = w_idx_ok ? w_rdata : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_text_color <= COLOR_RESET;
            r_cursor_en  <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_lin        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_lin   <= n_lin;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_TEXT_COLOR) begin
                    r_text_color <= i_cfg_wdata;
                end else if (i_cfg_index == REG_CURSOR_ENABLE) begin
                    r_cursor_en <= i_cfg_wdata[0];
                end
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_data <= n_data;
        if (w_accept) begin
            r_cmd  <= i_s_tuser;
            r_char <= i_s_tdata[7:0];
            r_idx  <= i_s_tdata[18:8];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_pos   <= w_lin_ext[POS_W-1:0];
            r_out_shown <= r_cursor_en;
            r_out_data  <= (r_cmd == CMD_READ) ? r_data : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_data, r_out_pos};
    assign o_m_tuser  = r_out_shown;

endmodule
